>>> design/aarch64_relocation_patcher_unit_macros.svh
// ------------------------------------------------------------------
// aarch64 relocation patcher assertion macros
// shared helpers for the concurrent checks on the unit ports
// ------------------------------------------------------------------
`ifndef AARCH64_RELOCATION_PATCHER_UNIT_MACROS_SVH
`define AARCH64_RELOCATION_PATCHER_UNIT_MACROS_SVH

// same-cycle implication, gated by reset
`define ARP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated by reset
`define ARP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/arp_pkg.sv
// ------------------------------------------------------------------
// arp_pkg
// relocation type codes, status codes and instruction field masks
// ------------------------------------------------------------------
`default_nettype none

package arp_pkg;

    typedef enum logic [4:0] {
        KIND_ABS64         = 5'd0,
        KIND_PREL64        = 5'd1,
        KIND_ABS32         = 5'd2,
        KIND_PREL32        = 5'd3,
        KIND_ABS16         = 5'd4,
        KIND_PREL16        = 5'd5,
        KIND_ADRP_PG_HI21  = 5'd6,
        KIND_JUMP26        = 5'd7,
        KIND_CALL26        = 5'd8,
        KIND_GOT_PAGE      = 5'd9,
        KIND_ADD_LO12      = 5'd10,
        KIND_LDST8_LO12    = 5'd11,
        KIND_LDST16_LO12   = 5'd12,
        KIND_LDST32_LO12   = 5'd13,
        KIND_LDST64_LO12   = 5'd14,
        KIND_LDST128_LO12  = 5'd15,
        KIND_LD64_GOT_LO12 = 5'd16
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_UNSUPPORTED = 3'd1,
        ST_NULL_ADDR   = 3'd2,
        ST_RANGE       = 3'd3,
        ST_MISALIGNED  = 3'd4,
        ST_SIZE        = 3'd5
    } t_status;

    localparam logic [3:0] BYTES_2 = 4'd2;
    localparam logic [3:0] BYTES_4 = 4'd4;
    localparam logic [3:0] BYTES_8 = 4'd8;

    // load/store unsigned-offset class detection
    localparam logic [31:0] LDST_CLASS_MASK  = 32'h3B00_0000;
    localparam logic [31:0] LDST_CLASS_MATCH = 32'h3900_0000;
    localparam logic [31:0] LDST_VECTOR_BITS = 32'h0480_0000;

    localparam logic [2:0] SCALE_QWORD = 3'd4;
    localparam logic [2:0] SCALE_DWORD = 3'd3;

endpackage

`default_nettype wire

>>> design/arp_ifs.sv
// ------------------------------------------------------------------
// arp channel interfaces
// valid/ready channels for relocation requests and patch results
// ------------------------------------------------------------------
`default_nettype none

interface arp_req_if;
    logic        valid;
    logic        ready;
    logic [4:0]  kind;
    logic [63:0] symbol_addr;
    logic [63:0] slot_addr;
    logic [63:0] place_addr;
    logic [63:0] addend;
    logic [31:0] old_insn;

    modport source (
        output valid, kind, symbol_addr, slot_addr, place_addr, addend, old_insn,
        input  ready
    );
    modport sink (
        input  valid, kind, symbol_addr, slot_addr, place_addr, addend, old_insn,
        output ready
    );
endinterface

interface arp_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] patched_value;
    logic [3:0]  write_bytes;
    logic [2:0]  status;

    modport source (
        output valid, patched_value, write_bytes, status,
        input  ready
    );
    modport sink (
        input  valid, patched_value, write_bytes, status,
        output ready
    );
endinterface

`default_nettype wire

>>> design/aarch64_relocation_patcher_unit.sv
// ------------------------------------------------------------------
// aarch64_relocation_patcher_unit
// applies one AArch64 ELF relocation per word: value, width, status
// ------------------------------------------------------------------
// usage:
//   i_req carries one relocation word (type code, S, G, P, A and the
//   instruction at P); o_rsp returns one result word per request with
//   the patched value, the byte count to write and a status code.
//   the result word passes the input register, then the result register,
//   after the request is accepted; one request per cycle sustained while
//   o_rsp is ready, with a single pass of add/mask/compare logic between
//   the two registers.
//   when o_rsp stalls, the result register holds its word and the input
//   register still takes one more word; i_req.ready drops only once both
//   are full, and rises again in the cycle the result is taken.
//   reset clears both valid flags; no words are held across reset.
//   a failed check gives a zero value, keeps the type's natural width
//   and reports the first failing check in the status.
// ------------------------------------------------------------------
`default_nettype none

module aarch64_relocation_patcher_unit
    import arp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    arp_req_if.sink    i_req,
    arp_rsp_if.source  o_rsp
);

    // input register
    logic        r_s1_valid;
    logic [4:0]  r_s1_kind;
    logic [63:0] r_s1_sym;
    logic [63:0] r_s1_got;
    logic [63:0] r_s1_place;
    logic [63:0] r_s1_addend;
    logic [31:0] r_s1_insn;

    // result register
    logic        r_out_valid;
    logic [63:0] r_out_value;
    logic [3:0]  r_out_bytes;
    logic [2:0]  r_out_status;

    logic        w_out_free;
    logic        w_s1_free;

    logic [63:0] n_value;
    logic [3:0]  n_bytes;
    t_status     n_status;

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_s1_free  = !r_s1_valid || w_out_free;
    assign i_req.ready = w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= i_req.valid;
        end
        if (w_s1_free && i_req.valid) begin
            r_s1_kind   <= i_req.kind;
            r_s1_sym    <= i_req.symbol_addr;
            r_s1_got    <= i_req.slot_addr;
            r_s1_place  <= i_req.place_addr;
            r_s1_addend <= i_req.addend;
            r_s1_insn   <= i_req.old_insn;
        end
    end

    // address arithmetic
    logic [63:0] w_sa;
    logic [63:0] w_ga;
    logic [63:0] w_sap;
    logic [63:0] w_pg_sym;
    logic [63:0] w_pg_got;
    logic [63:0] w_x;
    logic [11:0] w_x12;
    logic        w_fit16;
    logic        w_fit28;
    logic        w_fit32;
    logic        w_fit33;
    logic [2:0]  w_expect;
    logic [2:0]  w_scale;
    logic [3:0]  w_align_mask;
    logic        w_misaligned;
    logic [11:0] w_lo12_field;
    logic        w_is_got;

    assign w_sa     = r_s1_sym + r_s1_addend;
    assign w_ga     = r_s1_got + r_s1_addend;
    assign w_sap    = w_sa - r_s1_place;
    assign w_pg_sym = {w_sa[63:12], 12'h000} - {r_s1_place[63:12], 12'h000};
    assign w_pg_got = {w_ga[63:12], 12'h000} - {r_s1_place[63:12], 12'h000};
    assign w_is_got = (r_s1_kind == KIND_GOT_PAGE) || (r_s1_kind == KIND_LD64_GOT_LO12);

    always_comb begin
        unique case (r_s1_kind)
            KIND_ABS64, KIND_ABS32, KIND_ABS16: begin
                w_x = w_sa;
            end
            KIND_PREL64, KIND_PREL32, KIND_PREL16, KIND_JUMP26, KIND_CALL26: begin
                w_x = w_sap;
            end
            KIND_ADRP_PG_HI21: begin
                w_x = w_pg_sym;
            end
            KIND_GOT_PAGE: begin
                w_x = w_pg_got;
            end
            KIND_LD64_GOT_LO12: begin
                w_x = {52'd0, w_ga[11:0]};
            end
            default: begin
                w_x = {52'd0, w_sa[11:0]};
            end
        endcase
    end

    assign w_x12   = w_x[11:0];
    // signed fit: all bits from the sign position up agree
    assign w_fit16 = (w_x[63:15] == '0) || (w_x[63:15] == '1);
    assign w_fit28 = (w_x[63:27] == '0) || (w_x[63:27] == '1);
    assign w_fit32 = (w_x[63:31] == '0) || (w_x[63:31] == '1);
    assign w_fit33 = (w_x[63:32] == '0) || (w_x[63:32] == '1);

    always_comb begin
        if (r_s1_kind == KIND_LD64_GOT_LO12) begin
            w_expect = SCALE_DWORD;
        end else if (r_s1_kind >= KIND_LDST8_LO12) begin
            w_expect = 3'(r_s1_kind - KIND_LDST8_LO12);
        end else begin
            w_expect = 3'd0;
        end
    end

    assign w_align_mask = ~(4'hf << w_expect);
    assign w_misaligned = |(w_x12[3:0] & w_align_mask);

    // access size from the load/store encoding, vector q-form gives 4
    always_comb begin
        w_scale = 3'd0;
        if ((r_s1_insn & LDST_CLASS_MASK) == LDST_CLASS_MATCH) begin
            w_scale = {1'b0, r_s1_insn[31:30]};
            if (r_s1_insn[31:30] == 2'd0
                && (r_s1_insn & LDST_VECTOR_BITS) == LDST_VECTOR_BITS) begin
                w_scale = SCALE_QWORD;
            end
        end
    end

    assign w_lo12_field = w_x12 >> w_scale;

    always_comb begin
        if (r_s1_kind == KIND_ABS64 || r_s1_kind == KIND_PREL64) begin
            n_bytes = BYTES_8;
        end else if (r_s1_kind == KIND_ABS16 || r_s1_kind == KIND_PREL16) begin
            n_bytes = BYTES_2;
        end else begin
            n_bytes = BYTES_4;
        end
    end

    always_comb begin
        n_status = ST_OK;
        n_value  = 64'd0;
        priority if (r_s1_place == '0 || r_s1_sym == '0) begin
            n_status = ST_NULL_ADDR;
        end else if (r_s1_kind > KIND_LD64_GOT_LO12) begin
            n_status = ST_UNSUPPORTED;
        end else if (w_is_got && r_s1_got == '0) begin
            n_status = ST_NULL_ADDR;
        end else begin
            unique case (r_s1_kind)
                KIND_ABS64, KIND_PREL64: begin
                    n_value = w_x;
                end
                KIND_ABS32, KIND_PREL32: begin
                    if (!w_fit32) n_status = ST_RANGE;
                    else          n_value  = {32'd0, w_x[31:0]};
                end
                KIND_ABS16, KIND_PREL16: begin
                    if (!w_fit16) n_status = ST_RANGE;
                    else          n_value  = {48'd0, w_x[15:0]};
                end
                KIND_ADRP_PG_HI21, KIND_GOT_PAGE: begin
                    if (!w_fit33 || w_x12 != '0) begin
                        n_status = ST_RANGE;
                    end else begin
                        // immlo in 30:29, immhi in 23:5
                        n_value = {32'd0, r_s1_insn[31], w_x[13:12], r_s1_insn[28:24],
                                   w_x[32:14], r_s1_insn[4:0]};
                    end
                end
                KIND_JUMP26, KIND_CALL26: begin
                    if (!w_fit28) n_status = ST_RANGE;
                    else          n_value  = {32'd0, r_s1_insn[31:26], w_x[27:2]};
                end
                default: begin
                    if (w_misaligned) begin
                        n_status = ST_MISALIGNED;
                    end else if (w_x12 != '0 && w_expect != w_scale) begin
                        n_status = ST_SIZE;
                    end else begin
                        n_value = {32'd0, r_s1_insn[31:22], w_lo12_field, r_s1_insn[9:0]};
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
        if (w_out_free && r_s1_valid) begin
            r_out_value  <= n_value;
            r_out_bytes  <= n_bytes;
            r_out_status <= n_status;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.patched_value = r_out_value;
    assign o_rsp.write_bytes   = r_out_bytes;
    assign o_rsp.status        = r_out_status;

endmodule

`default_nettype wire

>>> design/arp_checker.sv
// ------------------------------------------------------------------
// arp_checker
// port-level checks on the relocation patcher, bound to the top level
// ------------------------------------------------------------------
`default_nettype none

`include "aarch64_relocation_patcher_unit_macros.svh"

module arp_checker
    import arp_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        i_in_ready,
    input wire        i_out_valid,
    input wire        i_out_ready,
    input wire [63:0] i_out_value,
    input wire [3:0]  i_out_bytes,
    input wire [2:0]  i_out_status
);

    // a stalled result word holds
    `ARP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_value) && $stable(i_out_bytes) && $stable(i_out_status), "stalled result word changed")

    // a failed relocation writes nothing meaningful
    `ARP_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, i_out_valid && i_out_status != ST_OK, i_out_value == 64'd0, "failed relocation with nonzero value")

    `ARP_ASSERT_IMPL(a_bytes_legal, i_clk, i_rst_n, i_out_valid, i_out_bytes == BYTES_2 || i_out_bytes == BYTES_4 || i_out_bytes == BYTES_8, "illegal write width")

    // an accepted word, with the sink kept ready, passes the input register and then shows on the result port
    `ARP_ASSERT_NEXT(a_latency, i_clk, i_rst_n, i_in_valid && i_in_ready && i_out_ready ##1 i_out_ready, i_out_valid, "result word missing after two cycles")

endmodule

bind aarch64_relocation_patcher_unit arp_checker u_arp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_out_value  (o_rsp.patched_value),
    .i_out_bytes  (o_rsp.write_bytes),
    .i_out_status (o_rsp.status)
);

`default_nettype wire
